@@ src/bb3_pkg.sv @@
// shared constants and types for the edge-aware 3x3 box blur
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int CHANNEL_BITS = 8;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    // counts that can hold the width plus one (fill count, pending results)
    localparam int CNT_BITS = COL_BITS + 1;
    localparam int WIDTH_BITS = 11;
    localparam int HEIGHT_BITS = 12;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);
    localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = HEIGHT_BITS'(480);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // nine taps of at most full scale fit in four extra bits
    localparam int SUM_BITS = CHANNEL_BITS + 4;

    localparam int WIN_TAPS = 9;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pix_t;

    // tap index is column slot * 3 + row slot, column slot 2 is the newest
    typedef pix_t [WIN_TAPS-1:0] win_t;

    typedef struct packed {
        logic row_above;
        logic row_below;
        logic col_left;
        logic col_right;
        logic frame_end;
    } mean_ctl_t;

endpackage

@@ src/bb3_in_if.sv @@
// pixel input channel: valid, ready and one pixel or drain word
interface bb3_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [bb3_pkg::CHANNEL_BITS-1:0] red_in;
    logic [bb3_pkg::CHANNEL_BITS-1:0] green_in;
    logic [bb3_pkg::CHANNEL_BITS-1:0] blue_in;

    modport source (
        output valid,
        output command,
        output red_in,
        output green_in,
        output blue_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  red_in,
        input  green_in,
        input  blue_in,
        output ready
    );
endinterface

@@ src/bb3_out_if.sv @@
// result channel: valid, ready and one averaged pixel word
interface bb3_out_if;
    logic                             valid;
    logic                             ready;
    logic [bb3_pkg::CHANNEL_BITS-1:0] red_out;
    logic [bb3_pkg::CHANNEL_BITS-1:0] green_out;
    logic [bb3_pkg::CHANNEL_BITS-1:0] blue_out;
    logic                             frame_end;

    modport source (
        output valid,
        output red_out,
        output green_out,
        output blue_out,
        output frame_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  red_out,
        input  green_out,
        input  blue_out,
        input  frame_end,
        output ready
    );
endinterface

@@ src/bb3_mean.sv @@
// masked window sum, divide by neighbor count and result output register
module bb3_mean (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bb3_pkg::win_t       window,
    input  bb3_pkg::mean_ctl_t  ctl,
    bb3_out_if.source           result,
    output logic                full
);

    localparam int RECIP_SHIFT = bb3_pkg::SUM_BITS + 3;
    localparam int RECIP_BITS = RECIP_SHIFT + 1;
    localparam int PROD_BITS = bb3_pkg::SUM_BITS + RECIP_BITS;
    // reciprocals rounded up; exact floor for every sum below 2**SUM_BITS
    localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(64'd1 << RECIP_SHIFT);
    localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(64'd1 << (RECIP_SHIFT - 1));
    localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(64'd1 << (RECIP_SHIFT - 2));
    localparam logic [RECIP_BITS-1:0] RECIP_3 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
    localparam logic [RECIP_BITS-1:0] RECIP_6 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);
    localparam logic [RECIP_BITS-1:0] RECIP_9 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);

    logic [bb3_pkg::SUM_BITS-1:0]     sum_red;
    logic [bb3_pkg::SUM_BITS-1:0]     sum_green;
    logic [bb3_pkg::SUM_BITS-1:0]     sum_blue;
    logic [2:0]                       col_ok;
    logic [2:0]                       row_ok;
    logic [1:0]                       rows_cnt;
    logic [1:0]                       cols_cnt;
    logic [RECIP_BITS-1:0]            recip;

    logic                             sum_valid_reg;
    logic                             sum_valid_next;
    logic [bb3_pkg::SUM_BITS-1:0]     sum_red_reg;
    logic [bb3_pkg::SUM_BITS-1:0]     sum_green_reg;
    logic [bb3_pkg::SUM_BITS-1:0]     sum_blue_reg;
    logic [RECIP_BITS-1:0]            recip_reg;
    logic                             sum_end_reg;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [bb3_pkg::CHANNEL_BITS-1:0] out_red_reg;
    logic [bb3_pkg::CHANNEL_BITS-1:0] out_green_reg;
    logic [bb3_pkg::CHANNEL_BITS-1:0] out_blue_reg;
    logic                             out_end_reg;

    logic                             advance;
    logic [PROD_BITS-1:0]             prod_red;
    logic [PROD_BITS-1:0]             prod_green;
    logic [PROD_BITS-1:0]             prod_blue;

    assign col_ok = {ctl.col_right, 1'b1, ctl.col_left};
    assign row_ok = {ctl.row_below, 1'b1, ctl.row_above};

    always_comb
    begin
        sum_red = '0;
        sum_green = '0;
        sum_blue = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (col_ok[c] && row_ok[r])
                begin
                    sum_red = sum_red + bb3_pkg::SUM_BITS'(window[c * 3 + r].red);
                    sum_green = sum_green + bb3_pkg::SUM_BITS'(window[c * 3 + r].green);
                    sum_blue = sum_blue + bb3_pkg::SUM_BITS'(window[c * 3 + r].blue);
                end
            end
        end
    end

    assign rows_cnt = {1'b0, ctl.row_above} + {1'b0, ctl.row_below};
    assign cols_cnt = {1'b0, ctl.col_left} + {1'b0, ctl.col_right};

    // divisor is (rows_cnt + 1) * (cols_cnt + 1)
    always_comb
    begin
        unique case ({rows_cnt, cols_cnt})
            4'b0000:          recip = RECIP_1;
            4'b0001, 4'b0100: recip = RECIP_2;
            4'b0010, 4'b1000: recip = RECIP_3;
            4'b0101:          recip = RECIP_4;
            4'b0110, 4'b1001: recip = RECIP_6;
            4'b1010:          recip = RECIP_9;
            default:          recip = RECIP_1;
        endcase
    end

    assign advance = sum_valid_reg && (!out_valid_reg || result.ready);
    assign full = sum_valid_reg && out_valid_reg;

    always_comb
    begin
        sum_valid_next = sum_valid_reg;
        if (load)
        begin
            sum_valid_next = 1'b1;
        end
        else if (advance)
        begin
            sum_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign prod_red = PROD_BITS'(sum_red_reg) * PROD_BITS'(recip_reg);
    assign prod_green = PROD_BITS'(sum_green_reg) * PROD_BITS'(recip_reg);
    assign prod_blue = PROD_BITS'(sum_blue_reg) * PROD_BITS'(recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_red_reg <= sum_red;
            sum_green_reg <= sum_green;
            sum_blue_reg <= sum_blue;
            recip_reg <= recip;
            sum_end_reg <= ctl.frame_end;
        end
        if (advance)
        begin
            out_red_reg <= prod_red[RECIP_SHIFT +: bb3_pkg::CHANNEL_BITS];
            out_green_reg <= prod_green[RECIP_SHIFT +: bb3_pkg::CHANNEL_BITS];
            out_blue_reg <= prod_blue[RECIP_SHIFT +: bb3_pkg::CHANNEL_BITS];
            out_end_reg <= sum_end_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.red_out = out_red_reg;
    assign result.green_out = out_green_reg;
    assign result.blue_out = out_blue_reg;
    assign result.frame_end = out_end_reg;

    // the shift interlock leaves the sum stage empty whenever a new sum arrives
    assert property (@(posedge clk) disable iff (!rst_n) load |-> !sum_valid_reg)
        else $error("sum stage overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("sum moved on but output register empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !result.ready) |=> full)
        else $error("stalled result pipeline lost a word");

endmodule

@@ src/box_blur_3x3_edge_aware.sv @@
// Edge-aware 3x3 box blur over an RGB raster stream. Each pixel word goes
// through a read of both line stores in the cycle it is accepted and the
// write-back and window shift in the next, a read-modify-write of the line
// stores; no new word is taken during the shift. A drain word that has
// nothing to do is taken without a shift. A result passes through the sum
// register of bb3_mean, then its output register. One result can wait there
// without stopping input; a second result held behind it stops input until
// the first is taken. Results lag their own pixel by width+1 words; after the
// last pixel of a frame, drain words push the remaining results out, and
// frame_end marks the last one. The line stores need no clearing pass after
// reset: the fill count holds results back until every counted tap comes
// from the current frame.
module box_blur_3x3_edge_aware (
    input  logic                               clk,
    input  logic                               rst_n,
    bb3_in_if.sink                             pixel,
    bb3_out_if.source                          result,
    input  logic                               write_enable,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0] register_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]  write_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SHIFT = 1'b1;

    logic                               state_reg;
    logic                               state_next;

    logic [bb3_pkg::WIDTH_BITS-1:0]     image_width_reg;
    logic [bb3_pkg::WIDTH_BITS-1:0]     image_width_next;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    image_height_reg;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    image_height_next;
    logic [bb3_pkg::CNT_BITS-1:0]       w_eff;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    h_eff;

    logic [bb3_pkg::COL_BITS-1:0]       in_col_reg;
    logic [bb3_pkg::COL_BITS-1:0]       in_col_next;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    in_row_reg;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    in_row_next;
    logic [bb3_pkg::COL_BITS-1:0]       out_col_reg;
    logic [bb3_pkg::COL_BITS-1:0]       out_col_next;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    out_row_reg;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    out_row_next;
    logic [bb3_pkg::CNT_BITS-1:0]       pending_reg;
    logic [bb3_pkg::CNT_BITS-1:0]       pending_next;
    logic [bb3_pkg::CNT_BITS-1:0]       fill_reg;
    logic [bb3_pkg::CNT_BITS-1:0]       fill_next;
    logic                               draining_reg;
    logic                               draining_next;

    logic                               accept;
    logic                               is_pixel;
    logic                               restart;
    logic                               drain_go;
    logic                               step;
    logic [bb3_pkg::COL_BITS-1:0]       base_in_col;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    base_in_row;
    logic [bb3_pkg::COL_BITS-1:0]       base_out_col;
    logic [bb3_pkg::HEIGHT_BITS-1:0]    base_out_row;
    logic [bb3_pkg::CNT_BITS-1:0]       base_pending;
    logic [bb3_pkg::CNT_BITS-1:0]       base_fill;
    logic [bb3_pkg::CNT_BITS-1:0]       in_col_inc;
    logic [bb3_pkg::HEIGHT_BITS:0]      in_row_inc;
    logic [bb3_pkg::CNT_BITS-1:0]       out_col_inc;
    logic [bb3_pkg::HEIGHT_BITS:0]      out_row_inc;
    logic [bb3_pkg::CNT_BITS-1:0]       w_plus;
    logic                               emit;
    bb3_pkg::mean_ctl_t                 ctl;

    logic                               emit_reg;
    logic                               emit_next;
    bb3_pkg::mean_ctl_t                 ctl_reg;
    logic [bb3_pkg::COL_BITS-1:0]       wr_col_reg;
    bb3_pkg::pix_t                      px_reg;

    bb3_pkg::pix_t                      upper_mem [bb3_pkg::MAX_WIDTH];
    bb3_pkg::pix_t                      middle_mem [bb3_pkg::MAX_WIDTH];
    bb3_pkg::pix_t                      upper_rd_reg;
    bb3_pkg::pix_t                      middle_rd_reg;
    logic                               mem_we;

    bb3_pkg::win_t                      win_reg;
    bb3_pkg::win_t                      win_next;

    logic                               mean_full;
    logic                               mean_load;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = bb3_pkg::CNT_BITS'(1);
        end
        else if (32'(image_width_reg) > 32'(bb3_pkg::MAX_WIDTH))
        begin
            w_eff = bb3_pkg::CNT_BITS'(bb3_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = bb3_pkg::CNT_BITS'(image_width_reg);
        end
    end

    assign h_eff = (image_height_reg == '0) ? bb3_pkg::HEIGHT_BITS'(1) : image_height_reg;

    assign pixel.ready = (state_reg == ST_IDLE) && !mean_full;
    assign accept = pixel.valid && pixel.ready;
    assign is_pixel = (pixel.command == bb3_pkg::CMD_PIXEL);
    // a pixel after drains began starts a fresh frame
    assign restart = is_pixel && draining_reg;
    assign drain_go = (pixel.command == bb3_pkg::CMD_DRAIN) && (pending_reg != '0)
                      && (draining_reg || (in_col_reg == '0 && in_row_reg == '0));
    assign step = is_pixel || drain_go;

    assign base_in_col = restart ? '0 : in_col_reg;
    assign base_in_row = restart ? '0 : in_row_reg;
    assign base_out_col = restart ? '0 : out_col_reg;
    assign base_out_row = restart ? '0 : out_row_reg;
    assign base_pending = restart ? '0 : pending_reg;
    assign base_fill = restart ? '0 : fill_reg;

    assign in_col_inc = {1'b0, base_in_col} + bb3_pkg::CNT_BITS'(1);
    assign in_row_inc = {1'b0, base_in_row} + (bb3_pkg::HEIGHT_BITS + 1)'(1);
    assign out_col_inc = {1'b0, base_out_col} + bb3_pkg::CNT_BITS'(1);
    assign out_row_inc = {1'b0, base_out_row} + (bb3_pkg::HEIGHT_BITS + 1)'(1);
    assign w_plus = w_eff + bb3_pkg::CNT_BITS'(1);
    // window full: the shift about to happen completes a result
    assign emit = (base_fill >= w_plus);

    always_comb
    begin
        ctl.row_above = (base_out_row != '0);
        ctl.row_below = (out_row_inc < {1'b0, h_eff});
        ctl.col_left = (base_out_col != '0);
        ctl.col_right = (out_col_inc < w_eff);
        ctl.frame_end = !ctl.row_below && !ctl.col_right;
    end

    always_comb
    begin
        image_width_next = image_width_reg;
        image_height_next = image_height_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        fill_next = fill_reg;
        draining_next = draining_reg;
        emit_next = emit_reg;
        priority if (write_enable)
        begin
            if (register_index == bb3_pkg::REG_IMAGE_WIDTH)
            begin
                image_width_next = write_data[bb3_pkg::WIDTH_BITS-1:0];
            end
            if (register_index == bb3_pkg::REG_IMAGE_HEIGHT)
            begin
                image_height_next = write_data[bb3_pkg::HEIGHT_BITS-1:0];
            end
            in_col_next = '0;
            in_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
            pending_next = '0;
            fill_next = '0;
            draining_next = 1'b0;
        end
        else if (accept && step)
        begin
            emit_next = emit;
            in_col_next = (in_col_inc >= w_eff) ? '0 : in_col_inc[bb3_pkg::COL_BITS-1:0];
            in_row_next = base_in_row;
            if (is_pixel && (in_col_inc >= w_eff))
            begin
                in_row_next = (in_row_inc >= {1'b0, h_eff}) ?
                              '0 : in_row_inc[bb3_pkg::HEIGHT_BITS-1:0];
            end
            out_col_next = base_out_col;
            out_row_next = base_out_row;
            if (emit)
            begin
                if (out_col_inc >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = (out_row_inc >= {1'b0, h_eff}) ?
                                   '0 : out_row_inc[bb3_pkg::HEIGHT_BITS-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[bb3_pkg::COL_BITS-1:0];
                end
            end
            pending_next = base_pending + bb3_pkg::CNT_BITS'(is_pixel)
                           - bb3_pkg::CNT_BITS'(emit);
            fill_next = emit ? w_plus : base_fill + bb3_pkg::CNT_BITS'(1);
            draining_next = !is_pixel;
        end
        else
        begin
            // no write and no window move: everything holds
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && step)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            image_width_reg <= bb3_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= bb3_pkg::IMAGE_HEIGHT_RESET;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            fill_reg <= '0;
            draining_reg <= 1'b0;
            emit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            image_width_reg <= image_width_next;
            image_height_reg <= image_height_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
            fill_reg <= fill_next;
            draining_reg <= draining_next;
            emit_reg <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step)
        begin
            wr_col_reg <= base_in_col;
            ctl_reg <= ctl;
            if (is_pixel)
            begin
                px_reg.red <= pixel.red_in;
                px_reg.green <= pixel.green_in;
                px_reg.blue <= pixel.blue_in;
            end
            else
            begin
                // drain stand-in lands outside the frame and is never counted
                px_reg <= '0;
            end
        end
    end

    // line stores: read on accept, write back during the shift cycle
    assign mem_we = (state_reg == ST_SHIFT);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[wr_col_reg] <= middle_rd_reg;
            middle_mem[wr_col_reg] <= px_reg;
        end
        if (accept)
        begin
            upper_rd_reg <= upper_mem[base_in_col];
            middle_rd_reg <= middle_mem[base_in_col];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win_next[i] = win_reg[i + 3];
        end
        win_next[6] = upper_rd_reg;
        win_next[7] = middle_rd_reg;
        win_next[8] = px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_reg <= win_next;
        end
    end

    assign mean_load = mem_we && emit_reg;

    bb3_mean u_mean (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (mean_load),
        .window (win_next),
        .ctl    (ctl_reg),
        .result (result),
        .full   (mean_full)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |=> (state_reg == ST_IDLE))
        else $error("shift cycle did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= w_plus) && (pending_reg <= fill_reg))
        else $error("fill count or pending count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, in_col_reg} < w_eff) && (in_row_reg < h_eff))
        else $error("input position outside the frame");

endmodule
